// ===== src/ott_pkg.sv =====
// ----------------------------------------------------------------------------
// One-shot timer table package
// Shared widths, codes and the structs passed between the control logic
// and the chain of timer cells.
// ----------------------------------------------------------------------------
package ott_pkg;

  // Default number of timer slots.
  localparam int SLOTS_DEF = 16;

  // Field widths.
  localparam int MODE_W   = 2;
  localparam int TIME_W   = 32;
  localparam int TAG_W    = 16;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 3;

  // Packed stream widths, rounded up to whole bytes.
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 56;

  // Operation codes carried in the input item.
  localparam logic [MODE_W-1:0] MODE_CREATE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_CREATED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_TO  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FIRED    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NONE_DUE = 3'd5;

  // Operation the cells carry out while the token passes them.
  typedef enum logic [1:0] {
    OP_NOP,
    OP_CREATE,
    OP_DELETE,
    OP_TICK
  } op_t;

  // Command broadcast to every cell for the item in flight.
  typedef struct packed {
    op_t               op;
    logic [TIME_W-1:0] deadline;
    logic [TIME_W-1:0] now;
    logic [TAG_W-1:0]  tag;
    logic [SLOT_W-1:0] sel;
  } cmd_t;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  tag;
  } tok_t;

endpackage

// ===== src/ott_cell.sv =====
// ----------------------------------------------------------------------------
// Timer cell
// Holds one slot (live flag, deadline, tag) and acts on the search token
// as it passes, then hands the token to the next cell in the following cycle.
// ----------------------------------------------------------------------------
module ott_cell #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ott_pkg::cmd_t cmd,
  input  ott_pkg::tok_t tok_in,
  output ott_pkg::tok_t tok_out
);

  localparam logic [ott_pkg::SLOT_W-1:0] IdxSlot = ott_pkg::SLOT_W'(IDX);

  logic                        live_r;
  logic                        live_nxt;
  logic [ott_pkg::TIME_W-1:0]  dl_r;
  logic [ott_pkg::TAG_W-1:0]   tag_r;
  logic                        wr_en;
  ott_pkg::tok_t               tok_r;
  ott_pkg::tok_t               tok_nxt;
  logic                        sel_hit;

  assign sel_hit = (int'(cmd.sel) == IDX);

  // Slot update and token pass-through.
  always_comb begin
    tok_nxt  = tok_in;
    live_nxt = live_r;
    wr_en    = 1'b0;
    if (tok_in.valid) begin
      unique case (cmd.op)
        ott_pkg::OP_CREATE: begin
          // First free slot along the chain takes the new timer.
          if (!tok_in.found && !live_r) begin
            live_nxt      = 1'b1;
            wr_en         = 1'b1;
            tok_nxt.found = 1'b1;
            tok_nxt.slot  = IdxSlot;
          end
        end
        ott_pkg::OP_TICK: begin
          // First live slot whose deadline has been reached fires.
          if (!tok_in.found && live_r && (cmd.now >= dl_r)) begin
            live_nxt      = 1'b0;
            tok_nxt.found = 1'b1;
            tok_nxt.slot  = IdxSlot;
            tok_nxt.tag   = tag_r;
          end
        end
        ott_pkg::OP_DELETE: begin
          if (sel_hit) begin
            live_nxt = 1'b0;
          end
        end
        ott_pkg::OP_NOP: begin
        end
      endcase
    end
  end

  // Live flag and token register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r      <= 1'b0;
      tok_r.valid <= 1'b0;
    end else begin
      live_r <= live_nxt;
      tok_r  <= tok_nxt;
    end
  end

  // Slot payload, written when a timer is created here.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      dl_r  <= cmd.deadline;
      tag_r <= cmd.tag;
    end
  end

  assign tok_out = tok_r;

endmodule

// ===== src/one_shot_timer_table.sv =====
// ----------------------------------------------------------------------------
// One-shot timer table
// An accepted item passes the start register, the token register of each cell in
// turn, the result register and the output register to out_tvalid. A search token
// walks the chain of timer cells one slot per cycle, and one item is in the
// chain at a time. A result still held in the output register delays the next.
// Reset: all slots free and the tick count zero; deadlines and tags are
// undefined until a timer is created in their slot.
// ----------------------------------------------------------------------------
module one_shot_timer_table #(
  parameter int SLOTS = ott_pkg::SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input items.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ott_pkg::IN_DATA_W-1:0]    in_tdata,  // timeout[31:0], task_tag[47:32],
                                                      // slot_sel[51:48], zero pad
  input  logic [ott_pkg::MODE_W-1:0]       in_tuser,  // mode[1:0]
  // Result items.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ott_pkg::OUT_DATA_W-1:0]   out_tdata, // slot[3:0], fired_tag[19:4],
                                                      // tick_now[51:20], zero pad
  output logic [ott_pkg::STATUS_W-1:0]     out_tuser  // status[2:0]
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                         state_r;
  logic                           start_r;
  logic [ott_pkg::TIME_W-1:0]     tick_r;
  logic [ott_pkg::MODE_W-1:0]     mode_r;
  logic                           zero_r;
  ott_pkg::cmd_t                  cmd_r;

  logic [ott_pkg::STATUS_W-1:0]   res_status_r;
  logic [ott_pkg::SLOT_W-1:0]     res_slot_r;
  logic [ott_pkg::TAG_W-1:0]      res_tag_r;
  logic [ott_pkg::STATUS_W-1:0]   res_status_nxt;
  logic [ott_pkg::SLOT_W-1:0]     res_slot_nxt;
  logic [ott_pkg::TAG_W-1:0]      res_tag_nxt;

  logic                           out_valid_r;
  logic [ott_pkg::STATUS_W-1:0]   out_status_r;
  logic [ott_pkg::SLOT_W-1:0]     out_slot_r;
  logic [ott_pkg::TAG_W-1:0]      out_tag_r;
  logic [ott_pkg::TIME_W-1:0]     out_tick_r;
  logic                           out_load;

  logic                           in_acc;
  logic [ott_pkg::MODE_W-1:0]     in_mode;
  logic [ott_pkg::TIME_W-1:0]     in_timeout;
  logic [ott_pkg::TAG_W-1:0]      in_tag;
  logic [ott_pkg::SLOT_W-1:0]     in_sel;
  logic [ott_pkg::TIME_W-1:0]     tick_inc;

  ott_pkg::tok_t                  tok [SLOTS+1];
  ott_pkg::tok_t                  chain_out;

  // Unpack the input item.
  assign in_mode    = in_tuser;
  assign in_timeout = in_tdata[31:0];
  assign in_tag     = in_tdata[47:32];
  assign in_sel     = in_tdata[51:48];
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign tick_inc   = tick_r + ott_pkg::TIME_W'(1);

  // Token entering the first cell.
  assign tok[0] = '{valid: start_r, found: 1'b0, slot: '0, tag: '0};

  // Chain of timer cells.
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    ott_cell #(
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd_r),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  assign chain_out = tok[SLOTS];

  // The finished result moves to the output register once that is free.
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // Result of the item from the token leaving the chain.
  always_comb begin
    res_status_nxt = ott_pkg::ST_NONE_DUE;
    res_slot_nxt   = '0;
    res_tag_nxt    = '0;
    unique case (mode_r)
      ott_pkg::MODE_CREATE: begin
        if (zero_r) begin
          res_status_nxt = ott_pkg::ST_ZERO_TO;
        end else if (chain_out.found) begin
          res_status_nxt = ott_pkg::ST_CREATED;
          res_slot_nxt   = chain_out.slot;
        end else begin
          res_status_nxt = ott_pkg::ST_FULL;
        end
      end
      ott_pkg::MODE_DELETE: begin
        res_status_nxt = ott_pkg::ST_DELETED;
      end
      ott_pkg::MODE_TICK: begin
        if (chain_out.found) begin
          res_status_nxt = ott_pkg::ST_FIRED;
          res_slot_nxt   = chain_out.slot;
          res_tag_nxt    = chain_out.tag;
        end
      end
      default: begin
      end
    endcase
  end

  // Control sequence, tick count and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= in_acc;
      // Output valid is set by a finished item and cleared when taken.
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            mode_r          <= in_mode;
            zero_r          <= (in_timeout == '0);
            cmd_r.deadline  <= tick_r + in_timeout;
            cmd_r.now       <= tick_inc;
            cmd_r.tag       <= in_tag;
            cmd_r.sel       <= in_sel;
            unique case (in_mode)
              ott_pkg::MODE_CREATE: begin
                cmd_r.op <= (in_timeout == '0) ? ott_pkg::OP_NOP : ott_pkg::OP_CREATE;
              end
              ott_pkg::MODE_DELETE: begin
                cmd_r.op <= ott_pkg::OP_DELETE;
              end
              ott_pkg::MODE_TICK: begin
                cmd_r.op <= ott_pkg::OP_TICK;
                tick_r   <= tick_inc;
              end
              default: begin
                cmd_r.op <= ott_pkg::OP_NOP;
              end
            endcase
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (chain_out.valid) begin
            res_status_r <= res_status_nxt;
            res_slot_r   <= res_slot_nxt;
            res_tag_r    <= res_tag_nxt;
            state_r      <= S_DONE;
          end
        end
        S_DONE: begin
          // Hand the result over once the output register is free.
          if (out_load) begin
            out_status_r <= res_status_r;
            out_slot_r   <= res_slot_r;
            out_tag_r    <= res_tag_r;
            out_tick_r   <= tick_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Pack the result item.
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {4'b0000, out_tick_r, out_tag_r, out_slot_r};

  // An accepted item keeps the input closed on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input still open after an item was accepted");

  // The token leaves the chain only while a search is in progress.
  a_token_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    chain_out.valid |-> (state_r == S_SCAN))
    else $error("search token left the chain outside a scan");

  // A new result only appears after a finished search.
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised without a finished search");

endmodule
